FILE: hdl/tbc_pkg.sv
package tbc_pkg;

    // Stack and name sizes.
    localparam int STACK_DEPTH = 32;
    localparam int MAX_TAG_LEN = 16;

    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
    localparam int POS_W   = $clog2(MAX_TAG_LEN + 1);
    localparam int IDX_W   = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;

    // Characters the scanner reacts to.
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_H     = 8'h68;
    localparam logic [7:0] CHAR_R     = 8'h72;

    // Scanner phase, one-hot.
    typedef enum logic [3:0] {
        PH_TEXT  = 4'b0001,
        PH_LT    = 4'b0010,
        PH_OPEN  = 4'b0100,
        PH_CLOSE = 4'b1000
    } phase_t;

    // Progress toward the void names br and hr.
    typedef enum logic [1:0] {
        VOID_NONE  = 2'd0,
        VOID_FIRST = 2'd1,
        VOID_FULL  = 2'd2
    } void_t;

    // Verdict and error codes.
    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_CLOSE     = 3'd1,
        VERDICT_OPEN_LEFT = 3'd2,
        VERDICT_CAPACITY  = 3'd3,
        VERDICT_UNTERM    = 3'd4
    } verdict_t;

    typedef logic [MAX_TAG_LEN-1:0][7:0] name_t;
    typedef logic [POS_W-1:0]            len_t;

    // Shift command broadcast to every stack cell.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_cmd_t;

    // Verdict formed on the last item of a text.
    typedef struct packed {
        verdict_t    verdict;
        logic [5:0]  depth;
    } result_t;

endpackage

FILE: hdl/tbc_cell.sv
module tbc_cell (
    input  logic                clk,
    input  tbc_pkg::stack_cmd_t cmd,
    input  tbc_pkg::name_t      upper_name,
    input  tbc_pkg::len_t       upper_len,
    input  tbc_pkg::name_t      lower_name,
    input  tbc_pkg::len_t       lower_len,
    output tbc_pkg::name_t      name,
    output tbc_pkg::len_t       len
);
    import tbc_pkg::*;

    name_t name_reg;
    len_t  len_reg;

    // A push moves every entry one level deeper; a pop moves it one level up.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            name_reg <= upper_name;
            len_reg  <= upper_len;
        end
        else if (cmd.pop)
        begin
            name_reg <= lower_name;
            len_reg  <= lower_len;
        end
    end

    assign name = name_reg;
    assign len  = len_reg;

endmodule

FILE: hdl/tbc_scan.sv
module tbc_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          text_byte,
    input  logic                byte_present,
    input  logic                end_of_text,
    input  tbc_pkg::name_t      top_name,
    input  tbc_pkg::len_t       top_len,
    output tbc_pkg::stack_cmd_t cmd,
    output tbc_pkg::name_t      push_name,
    output tbc_pkg::len_t       push_len,
    output tbc_pkg::result_t    result
);
    import tbc_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    len_t               pos_reg, pos_next;
    logic               differs_reg, differs_next;
    void_t              void_reg, void_next;
    verdict_t           err_reg, err_next;
    name_t              buf_reg, buf_next;

    // Scanner step for one accepted byte.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        differs_next = differs_reg;
        void_next    = void_reg;
        err_next     = err_reg;
        buf_next     = buf_reg;
        cmd          = '0;

        if (in_fire && byte_present && (err_reg == VERDICT_OK))
        begin
            case (phase_reg)
                PH_TEXT:
                begin
                    if (text_byte == CHAR_LT)
                        phase_next = PH_LT;
                end
                PH_LT:
                begin
                    pos_next  = '0;
                    void_next = VOID_NONE;
                    if (text_byte == CHAR_SLASH)
                    begin
                        differs_next = (count_reg == '0);
                        phase_next   = PH_CLOSE;
                    end
                    else if (text_byte == CHAR_GT)
                    begin
                        // Empty name, never void.
                        if (count_reg >= COUNT_W'(STACK_DEPTH))
                            err_next = VERDICT_CAPACITY;
                        else
                        begin
                            cmd.push   = 1'b1;
                            count_next = COUNT_W'(count_reg + 1'b1);
                        end
                        phase_next = PH_TEXT;
                    end
                    else
                    begin
                        phase_next  = PH_OPEN;
                        buf_next[0] = text_byte;
                        void_next   = ((text_byte == CHAR_B) || (text_byte == CHAR_H)) ?
                                      VOID_FIRST : VOID_NONE;
                        pos_next    = POS_W'(1);
                    end
                end
                PH_OPEN:
                begin
                    if (text_byte == CHAR_GT)
                    begin
                        if (!((void_reg == VOID_FULL) && (pos_reg == POS_W'(2))))
                        begin
                            if (count_reg >= COUNT_W'(STACK_DEPTH))
                                err_next = VERDICT_CAPACITY;
                            else
                            begin
                                cmd.push   = 1'b1;
                                count_next = COUNT_W'(count_reg + 1'b1);
                            end
                        end
                        phase_next = PH_TEXT;
                    end
                    else if (pos_reg >= POS_W'(MAX_TAG_LEN))
                        err_next = VERDICT_CAPACITY;
                    else
                    begin
                        buf_next[pos_reg[IDX_W-1:0]] = text_byte;
                        if (pos_reg == POS_W'(1))
                            void_next = ((void_reg == VOID_FIRST) && (text_byte == CHAR_R)) ?
                                        VOID_FULL : VOID_NONE;
                        else
                            void_next = VOID_NONE;
                        pos_next = POS_W'(pos_reg + 1'b1);
                    end
                end
                default:
                begin
                    if (text_byte == CHAR_GT)
                    begin
                        if (differs_reg || (count_reg == '0) || (pos_reg != top_len))
                            err_next = VERDICT_CLOSE;
                        else
                        begin
                            cmd.pop    = 1'b1;
                            count_next = COUNT_W'(count_reg - 1'b1);
                        end
                        phase_next = PH_TEXT;
                    end
                    else if (pos_reg >= POS_W'(MAX_TAG_LEN))
                        err_next = VERDICT_CAPACITY;
                    else
                    begin
                        // Compare against the name on top of the stack.
                        if (differs_reg || (count_reg == '0) || (pos_reg >= top_len) ||
                            (top_name[pos_reg[IDX_W-1:0]] != text_byte))
                            differs_next = 1'b1;
                        pos_next = POS_W'(pos_reg + 1'b1);
                    end
                end
            endcase
        end
    end

    // Verdict from the state after the last byte.
    always_comb
    begin
        if (err_next != VERDICT_OK)
            result.verdict = err_next;
        else if (phase_next != PH_TEXT)
            result.verdict = VERDICT_UNTERM;
        else if (count_next != '0)
            result.verdict = VERDICT_OPEN_LEFT;
        else
            result.verdict = VERDICT_OK;
        result.depth = (32'(count_next) > 32'd63) ? 6'd63 : 6'(count_next);
    end

    assign push_name = buf_next;
    assign push_len  = pos_next;

    // Control state; the end of a text returns it to the reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TEXT;
            count_reg   <= '0;
            pos_reg     <= '0;
            differs_reg <= 1'b0;
            void_reg    <= VOID_NONE;
            err_reg     <= VERDICT_OK;
        end
        else if (in_fire && end_of_text)
        begin
            phase_reg   <= PH_TEXT;
            count_reg   <= '0;
            pos_reg     <= '0;
            differs_reg <= 1'b0;
            void_reg    <= VOID_NONE;
            err_reg     <= VERDICT_OK;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            differs_reg <= differs_next;
            void_reg    <= void_next;
            err_reg     <= err_next;
        end
    end

    // Buffer for the opening name being collected.
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

FILE: hdl/markup_tag_balance_checker_top.sv
// The verdict is valid in the cycle after the transfer that carries end_of_text.
// Throughput: one byte per cycle; each byte is scanned and the cell row shifts in that cycle.
// The input stalls only while a verdict waits in the output register and out_ready is low.
// Reset (rst_n low, asynchronous): no tags open, scanner in plain text, no error,
// no verdict pending. The name stack itself is not cleared.
module markup_tag_balance_checker_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       byte_present,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       well_formed,
    output logic [2:0] verdict,
    output logic [5:0] open_depth
);
    import tbc_pkg::*;

    logic       in_fire;
    stack_cmd_t cmd;
    name_t      push_name;
    len_t       push_len;
    result_t    result;
    name_t      cell_name [STACK_DEPTH];
    len_t       cell_len  [STACK_DEPTH];

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Tag scanner and name buffer.
    tbc_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .text_byte    (text_byte),
        .byte_present (byte_present),
        .end_of_text  (end_of_text),
        .top_name     (cell_name[0]),
        .top_len      (cell_len[0]),
        .cmd          (cmd),
        .push_name    (push_name),
        .push_len     (push_len),
        .result       (result)
    );

    // Row of stack cells; cell 0 holds the top of the stack.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        name_t upper_name, lower_name;
        len_t  upper_len, lower_len;

        if (i == 0)
        begin : g_first
            assign upper_name = push_name;
            assign upper_len  = push_len;
        end
        else
        begin : g_inner
            assign upper_name = cell_name[i-1];
            assign upper_len  = cell_len[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign lower_name = cell_name[i];
            assign lower_len  = cell_len[i];
        end
        else
        begin : g_mid
            assign lower_name = cell_name[i+1];
            assign lower_len  = cell_len[i+1];
        end

        tbc_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .upper_name (upper_name),
            .upper_len  (upper_len),
            .lower_name (lower_name),
            .lower_len  (lower_len),
            .name       (cell_name[i]),
            .len        (cell_len[i])
        );
    end

    // Output register for the verdict transfer.
    always_comb
    begin
        if (in_fire && end_of_text)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && end_of_text)
            out_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign verdict     = out_reg.verdict;
    assign well_formed = (out_reg.verdict == VERDICT_OK);
    assign open_depth  = out_reg.depth;

endmodule

FILE: hdl/tbc_checker.sv
module tbc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       end_of_text,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       well_formed,
    input  logic [2:0] verdict,
    input  logic [5:0] open_depth
);
    import tbc_pkg::*;

    // A verdict waiting for the sink holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(open_depth))
        else $error("verdict changed while stalled");

    // The last byte of a text always produces a verdict in the next cycle.
    a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_text |=> out_valid)
        else $error("no verdict after end of text");

    // The flag and the code agree.
    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (well_formed == (verdict == VERDICT_OK)))
        else $error("well_formed disagrees with verdict");

    // A clean text leaves nothing open; unclosed tags leave something open.
    a_depth_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == VERDICT_OK) |-> (open_depth == 6'd0))
        else $error("clean verdict with open tags");

    a_depth_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == VERDICT_OPEN_LEFT) |-> (open_depth != 6'd0))
        else $error("unclosed verdict with no open tags");

endmodule

bind markup_tag_balance_checker_top tbc_checker u_tbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .well_formed (well_formed),
    .verdict     (verdict),
    .open_depth  (open_depth)
);
